/* rtl/fsq_pkg.sv */
package fsq_pkg;

    localparam int MaxProcs = 32;
    localparam int PidW = 6;
    localparam int SlotW = 5;
    localparam int CntW = 6;
    localparam int RecW = 40;
    localparam int NumQ = 5;

    localparam logic [2:0] Q_HIGH = 3'd0;
    localparam logic [2:0] Q_LOW = 3'd1;
    localparam logic [2:0] Q_DISK = 3'd2;
    localparam logic [2:0] Q_TAPE = 3'd3;
    localparam logic [2:0] Q_PRN = 3'd4;

    localparam logic [1:0] REG_QUANTUM = 2'd0;
    localparam logic [1:0] REG_DISK = 2'd1;
    localparam logic [1:0] REG_TAPE = 2'd2;
    localparam logic [1:0] REG_PRN = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADMIT = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] burst_time;
        logic [7:0] disk_io_at;
        logic [7:0] tape_io_at;
        logic [7:0] printer_io_at;
    } in_item_t;

    typedef struct packed {
        logic       running_valid;
        logic [5:0] running_pid;
        logic       finished_valid;
        logic [5:0] finished_pid;
        logic [5:0] admitted_pid;
        logic       system_idle;
    } out_item_t;

    typedef struct packed {
        logic [7:0] remaining;
        logic [7:0] run_time;
        logic [7:0] disk_at;
        logic [7:0] tape_at;
        logic [7:0] printer_at;
    } proc_rec_t;

endpackage

/* rtl/feedback_scheduler_with_io_queues_top.sv */
// Two-level round-robin scheduler with disk, tape and printer queues. A tick
// walks the three devices (read head, release), then the running process (read
// record, write back, finish, block or preempt), then the dispatch (pop, load
// pid), and then the result register is loaded. All five queues share one pid
// memory (one write and one read port, slot = queue*32+index), process records
// sit in a second memory, at most one write to each memory per step. The input
// side stays blocked while a result waits, so with no output stall the next
// item is accepted in the cycle after the previous result is taken.
module feedback_scheduler_with_io_queues_top
    import fsq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DRD   = 9'b000000010,
        S_DCHK  = 9'b000000100,
        S_RRD   = 9'b000001000,
        S_RUPD  = 9'b000010000,
        S_DISP  = 9'b000100000,
        S_DISPW = 9'b001000000,
        S_ADM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] quantum_reg, dsvc_reg, tsvc_reg, psvc_reg;
    logic [SlotW-1:0] head_reg [NumQ];
    logic [CntW-1:0]  cnt_reg [NumQ];
    logic [PidW-1:0] next_pid_reg, cur_pid_reg, fin_pid_reg, adm_pid_reg;
    logic cpu_busy_reg, fin_reg;
    logic [7:0] slice_reg;
    logic [7:0] wait_reg [3];
    logic seen_reg [3];
    logic [PidW-1:0] seen_pid_reg [3];
    logic [1:0] dev_reg;
    in_item_t item_reg;
    logic [1:0] disp_q_reg;

    // pid memory
    logic q_we;
    logic [7:0] q_waddr, q_raddr;
    logic [PidW-1:0] q_wdata, q_rdata;
    fsq_ram #(.Width(PidW), .Depth(256)) u_qmem (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));

    logic p_we;
    logic [SlotW-1:0] p_waddr, p_raddr;
    proc_rec_t p_wdata, p_rdata;
    fsq_ram #(.Width(RecW), .Depth(MaxProcs)) u_pmem (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic [2:0] dq;
    assign dq = 3'(dev_reg) + Q_DISK;

    function automatic logic [7:0] tail_addr(logic [2:0] q, logic [SlotW-1:0] h,
                                             logic [CntW-1:0] c);
        logic [SlotW-1:0] t;
        t = h + c[SlotW-1:0];
        return {q, t};
    endfunction

    logic [7:0] svc;
    always_comb begin
        unique case (dev_reg)
            2'd0:    svc = dsvc_reg;
            2'd1:    svc = tsvc_reg;
            default: svc = psvc_reg;
        endcase
    end

    proc_rec_t upd;
    logic [7:0] slice_inc;
    always_comb begin
        upd = p_rdata;
        if (upd.remaining != 8'd0) upd.remaining = upd.remaining - 8'd1;
        if (upd.run_time != 8'hFF) upd.run_time = upd.run_time + 8'd1;
        slice_inc = (slice_reg != 8'hFF) ? slice_reg + 8'd1 : slice_reg;
    end

    logic all_empty;
    always_comb begin
        all_empty = 1'b1;
        for (int i = 0; i < NumQ; i++) begin
            if (cnt_reg[i] != '0) all_empty = 1'b0;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid;

    always_comb begin
        state_next = state_reg;
        q_raddr = {dq, head_reg[dq]};
        p_raddr = cur_pid_reg[SlotW-1:0] - SlotW'(1);
        unique case (state_reg)
            S_DRD:   q_raddr = {dq, head_reg[dq]};
            S_DISP:  q_raddr = (cnt_reg[Q_HIGH] != '0) ? {Q_HIGH, head_reg[Q_HIGH]}
                                                     : {Q_LOW, head_reg[Q_LOW]};
            default: ;
        endcase
        unique case (state_reg)
            S_IDLE:  if (s_valid && s_ready)
                         state_next = (s_data.command == CMD_ADMIT) ? S_ADM : S_DRD;
            S_DRD:   state_next = S_DCHK;
            S_DCHK:  state_next = (dev_reg == 2'd2) ? S_RRD : S_DRD;
            S_RRD:   state_next = S_RUPD;
            S_RUPD:  state_next = S_DISP;
            S_DISP:  state_next = S_DISPW;
            S_DISPW: state_next = S_OUT;
            S_ADM:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // device release, block or preempt decision and the memory write ports
    logic release_now, cpu_exit;
    logic [2:0] exit_q;
    always_comb begin
        release_now = (state_reg == S_DCHK) && (cnt_reg[dq] != '0) &&
                      (((seen_reg[dev_reg] && seen_pid_reg[dev_reg] == q_rdata &&
                         wait_reg[dev_reg] != 8'hFF) ? wait_reg[dev_reg] + 8'd1
                                                     : wait_reg[dev_reg]) >= svc);
        cpu_exit = 1'b0;
        exit_q = Q_LOW;
        if (upd.remaining == 8'd0) begin
            cpu_exit = 1'b0;
        end else if (upd.disk_at == upd.run_time) begin
            cpu_exit = 1'b1; exit_q = Q_DISK;
        end else if (upd.tape_at == upd.run_time) begin
            cpu_exit = 1'b1; exit_q = Q_TAPE;
        end else if (upd.printer_at == upd.run_time) begin
            cpu_exit = 1'b1; exit_q = Q_PRN;
        end else if (slice_inc == quantum_reg) begin
            cpu_exit = 1'b1; exit_q = Q_LOW;
        end
        q_we = 1'b0;
        q_waddr = '0;
        q_wdata = q_rdata;
        p_we = 1'b0;
        p_waddr = p_raddr;
        p_wdata = upd;
        if (state_reg == S_DCHK && release_now) begin
            q_we = 1'b1;
            q_waddr = (dev_reg == 2'd0) ? tail_addr(Q_LOW, head_reg[Q_LOW], cnt_reg[Q_LOW])
                                        : tail_addr(Q_HIGH, head_reg[Q_HIGH], cnt_reg[Q_HIGH]);
        end else if (state_reg == S_RUPD && cpu_busy_reg) begin
            p_we = 1'b1;
            q_we = cpu_exit;
            q_wdata = cur_pid_reg;
            q_waddr = tail_addr(exit_q, head_reg[exit_q], cnt_reg[exit_q]);
        end else if (state_reg == S_ADM && next_pid_reg <= PidW'(MaxProcs)) begin
            p_we = 1'b1;
            p_waddr = next_pid_reg[SlotW-1:0] - SlotW'(1);
            p_wdata = '{remaining: item_reg.burst_time, run_time: 8'd0,
                        disk_at: item_reg.disk_io_at, tape_at: item_reg.tape_io_at,
                        printer_at: item_reg.printer_io_at};
            q_we = 1'b1;
            q_wdata = next_pid_reg;
            q_waddr = tail_addr(Q_HIGH, head_reg[Q_HIGH], cnt_reg[Q_HIGH]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            quantum_reg <= 8'd2; dsvc_reg <= 8'd2; tsvc_reg <= 8'd5; psvc_reg <= 8'd7;
            for (int i = 0; i < NumQ; i++) begin
                head_reg[i] <= '0; cnt_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                wait_reg[i] <= '0; seen_reg[i] <= 1'b0; seen_pid_reg[i] <= '0;
            end
            next_pid_reg <= PidW'(1);
            cpu_busy_reg <= 1'b0; cur_pid_reg <= '0; slice_reg <= '0;
            dev_reg <= '0; m_valid <= 1'b0; fin_reg <= 1'b0;
            fin_pid_reg <= '0; adm_pid_reg <= '0; disp_q_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_QUANTUM: quantum_reg <= cfg_data;
                    REG_DISK:    dsvc_reg <= cfg_data;
                    REG_TAPE:    tsvc_reg <= cfg_data;
                    REG_PRN:     psvc_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    item_reg <= s_data;
                    dev_reg <= '0; fin_reg <= 1'b0; fin_pid_reg <= '0; adm_pid_reg <= '0;
                end
                S_DCHK: begin
                    if (cnt_reg[dq] != '0 && seen_reg[dev_reg] &&
                        seen_pid_reg[dev_reg] == q_rdata && wait_reg[dev_reg] != 8'hFF)
                        wait_reg[dev_reg] <= wait_reg[dev_reg] + 8'd1;
                    seen_reg[dev_reg] <= (cnt_reg[dq] != '0);
                    seen_pid_reg[dev_reg] <= (cnt_reg[dq] != '0) ? q_rdata : '0;
                    if (release_now) begin
                        wait_reg[dev_reg] <= '0;
                        head_reg[dq] <= head_reg[dq] + SlotW'(1);
                        cnt_reg[dq] <= cnt_reg[dq] - CntW'(1);
                        if (dev_reg == 2'd0) cnt_reg[Q_LOW] <= cnt_reg[Q_LOW] + CntW'(1);
                        else cnt_reg[Q_HIGH] <= cnt_reg[Q_HIGH] + CntW'(1);
                    end
                    // wrap after the printer so the device index stays in range
                    dev_reg <= (dev_reg == 2'd2) ? 2'd0 : dev_reg + 2'd1;
                end
                S_RUPD: if (cpu_busy_reg) begin
                    slice_reg <= slice_inc;
                    if (upd.remaining == 8'd0) begin
                        fin_reg <= 1'b1; fin_pid_reg <= cur_pid_reg;
                        cpu_busy_reg <= 1'b0; cur_pid_reg <= '0;
                    end else if (cpu_exit) begin
                        cnt_reg[exit_q] <= cnt_reg[exit_q] + CntW'(1);
                        cpu_busy_reg <= 1'b0; cur_pid_reg <= '0;
                    end
                end
                S_DISP: if (!cpu_busy_reg) begin
                    // pop high first, else low
                    if (cnt_reg[Q_HIGH] != '0) begin
                        head_reg[Q_HIGH] <= head_reg[Q_HIGH] + SlotW'(1);
                        cnt_reg[Q_HIGH] <= cnt_reg[Q_HIGH] - CntW'(1);
                        disp_q_reg <= 2'd1;
                    end else if (cnt_reg[Q_LOW] != '0) begin
                        head_reg[Q_LOW] <= head_reg[Q_LOW] + SlotW'(1);
                        cnt_reg[Q_LOW] <= cnt_reg[Q_LOW] - CntW'(1);
                        disp_q_reg <= 2'd2;
                    end else begin
                        disp_q_reg <= 2'd0;
                    end
                end else begin
                    disp_q_reg <= 2'd0;
                end
                S_DISPW: if (disp_q_reg != 2'd0) begin
                    cpu_busy_reg <= 1'b1; cur_pid_reg <= q_rdata; slice_reg <= '0;
                end
                S_ADM: if (next_pid_reg <= PidW'(MaxProcs)) begin
                    adm_pid_reg <= next_pid_reg;
                    cnt_reg[Q_HIGH] <= cnt_reg[Q_HIGH] + CntW'(1);
                    next_pid_reg <= next_pid_reg + PidW'(1);
                end
                S_OUT: begin
                    m_valid <= 1'b1;
                    m_data <= '{running_valid: cpu_busy_reg,
                                running_pid: cpu_busy_reg ? cur_pid_reg : '0,
                                finished_valid: fin_reg, finished_pid: fin_pid_reg,
                                admitted_pid: adm_pid_reg,
                                system_idle: all_empty && !cpu_busy_reg};
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/fsq_ram.sv */
module fsq_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
